// ----- design/color_key_span_extractor_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the color key span extractor
// Shared concurrent assertion forms, reset-qualified.
// ----------------------------------------------------------------------------
`ifndef COLOR_KEY_SPAN_EXTRACTOR_MACROS_SVH
`define COLOR_KEY_SPAN_EXTRACTOR_MACROS_SVH

// same-cycle implication
`define CKSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("span extractor assertion failed");

// next-cycle implication
`define CKSE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("span extractor assertion failed");

`endif

// ----- design/ckse_pkg.sv -----
// ----------------------------------------------------------------------------
// ckse_pkg
// Types and constants shared by the color key span extractor modules.
// ----------------------------------------------------------------------------
package ckse_pkg;

	localparam int COORD_W   = 12;
	localparam int KEY_W     = 32;
	localparam int LAYER_W   = 8;
	localparam int DIM_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam int Q_DEPTH   = 3;
	localparam int Q_CNT_W   = 2;

	localparam logic [DIM_W-1:0]   ROW_WIDTH_RST = 13'd640;
	localparam logic [DIM_W-1:0]   ROW_COUNT_RST = 13'd480;
	localparam logic [LAYER_W-1:0] LAYER_RST     = 8'd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_WIDTH = 2'd0,
		REG_ROW_COUNT = 2'd1,
		REG_LAYER     = 2'd2
	} cfg_reg_e;

	typedef struct packed {
		logic [DIM_W-1:0]   row_width;
		logic [DIM_W-1:0]   row_count;
		logic [LAYER_W-1:0] layer;
	} cfg_t;

	typedef struct packed {
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] left_col;
		logic [COORD_W-1:0] right_col;
		logic [KEY_W-1:0]   color_key;
		logic [LAYER_W-1:0] span_layer;
		logic               last;
	} span_t;

	typedef struct packed {
		logic [1:0] count;
		span_t      first;
		span_t      second;
	} core_res_t;

endpackage

// ----- design/color_key_span_extractor.sv -----
// ----------------------------------------------------------------------------
// color_key_span_extractor: run-length spans of equal nonzero color key
// Pixels wait in the input register; their spans pass via the result queue.
// One pixel per cycle while the queue has room for two spans; a pixel closing
// two spans holds off the next pixel even with the output ready, longer while
// the output stalls (result queue of 3 entries). Reset clears all scan state;
// registers return to 640 x 480, layer 1.
// ----------------------------------------------------------------------------
module color_key_span_extractor #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ckse_pkg::KEY_W-1:0]         pixel_key,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ckse_pkg::COORD_W-1:0]       row,
	output logic [ckse_pkg::COORD_W-1:0]       left_col,
	output logic [ckse_pkg::COORD_W-1:0]       right_col,
	output logic [ckse_pkg::KEY_W-1:0]         color_key,
	output logic [ckse_pkg::LAYER_W-1:0]       span_layer,
	output logic                               last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ckse_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ckse_pkg::DIM_W-1:0]         cfg_data
);

	ckse_pkg::cfg_t             cfg_q;
	logic                       vld_s1;
	logic [ckse_pkg::KEY_W-1:0] pix_s1;
	logic                       room;
	logic                       fire;
	ckse_pkg::core_res_t        res;
	ckse_pkg::span_t            head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_width <= ckse_pkg::ROW_WIDTH_RST;
			cfg_q.row_count <= ckse_pkg::ROW_COUNT_RST;
			cfg_q.layer     <= ckse_pkg::LAYER_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				ckse_pkg::REG_ROW_WIDTH: cfg_q.row_width <= cfg_data;
				ckse_pkg::REG_ROW_COUNT: cfg_q.row_count <= cfg_data;
				ckse_pkg::REG_LAYER:     cfg_q.layer     <= cfg_data[ckse_pkg::LAYER_W-1:0];
				default: ;
			endcase
		end
	end

	// process the held pixel once the queue can take two spans
	assign fire     = vld_s1 && room;
	assign in_ready = !vld_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			pix_s1 <= pixel_key;
	end

	ckse_span_core #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.pixel_key (pix_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	ckse_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.res       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign row        = head.row;
	assign left_col   = head.left_col;
	assign right_col  = head.right_col;
	assign color_key  = head.color_key;
	assign span_layer = head.span_layer;
	assign last       = head.last;

endmodule

// ----- design/ckse_span_core.sv -----
// ----------------------------------------------------------------------------
// ckse_span_core
// Scan position and open span state; forms up to two closed spans per pixel.
// ----------------------------------------------------------------------------
module ckse_span_core #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       fire,
	input  logic [ckse_pkg::KEY_W-1:0] pixel_key,
	input  ckse_pkg::cfg_t             cfg,
	output ckse_pkg::core_res_t        res
);

	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int WMW  = $clog2(MAX_WIDTH + 1);
	localparam int HMW  = $clog2(MAX_HEIGHT + 1);
	localparam int WXW  = (WMW > ckse_pkg::DIM_W) ? WMW : ckse_pkg::DIM_W;
	localparam int HXW  = (HMW > ckse_pkg::DIM_W) ? HMW : ckse_pkg::DIM_W;

	logic [CW-1:0]              col_q;
	logic [RW-1:0]              row_q;
	logic                       span_open_q;
	logic [ckse_pkg::KEY_W-1:0] open_key_q;
	logic [CW-1:0]              open_start_q;

	logic [WXW-1:0] width_req;
	logic [WXW-1:0] eff_width;
	logic [HXW-1:0] height_req;
	logic [HXW-1:0] eff_height;
	logic           row_end;
	logic           row_wrap;
	logic           key_nz;
	logic           key_same;
	logic           close_open;
	logic           close_end;
	ckse_pkg::span_t span_a;
	ckse_pkg::span_t span_b;

	// clamp the configured dimensions to 1..MAX
	always_comb begin
		width_req  = WXW'(cfg.row_width);
		height_req = HXW'(cfg.row_count);
		if (width_req == '0)
			eff_width = WXW'(1);
		else if (width_req > WXW'(MAX_WIDTH))
			eff_width = WXW'(MAX_WIDTH);
		else
			eff_width = width_req;
		if (height_req == '0)
			eff_height = HXW'(1);
		else if (height_req > HXW'(MAX_HEIGHT))
			eff_height = HXW'(MAX_HEIGHT);
		else
			eff_height = height_req;
	end

	assign row_end    = WXW'(col_q) >= (eff_width - WXW'(1));
	assign row_wrap   = (HXW'(row_q) + HXW'(1)) >= eff_height;
	assign key_nz     = pixel_key != '0;
	assign key_same   = pixel_key == open_key_q;
	assign close_open = span_open_q && (!key_nz || !key_same);
	assign close_end  = key_nz && row_end;

	always_comb begin
		span_a.row        = ckse_pkg::COORD_W'(row_q);
		span_a.left_col   = ckse_pkg::COORD_W'(open_start_q);
		span_a.right_col  = ckse_pkg::COORD_W'(col_q) - ckse_pkg::COORD_W'(1);
		span_a.color_key  = open_key_q;
		span_a.span_layer = cfg.layer;
		span_a.last       = !close_end;

		span_b.row        = ckse_pkg::COORD_W'(row_q);
		span_b.left_col   = (span_open_q && key_same) ? ckse_pkg::COORD_W'(open_start_q)
		                                              : ckse_pkg::COORD_W'(col_q);
		span_b.right_col  = ckse_pkg::COORD_W'(col_q);
		span_b.color_key  = pixel_key;
		span_b.span_layer = cfg.layer;
		span_b.last       = 1'b1;

		res.count  = 2'(close_open) + 2'(close_end);
		res.first  = close_open ? span_a : span_b;
		res.second = span_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			span_open_q  <= 1'b0;
			open_key_q   <= '0;
			open_start_q <= '0;
		end else if (fire) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
			// a zero pixel or a row end drops the open span and its key
			if (!key_nz || row_end) begin
				span_open_q <= 1'b0;
				open_key_q  <= '0;
			end else if (!span_open_q || !key_same) begin
				span_open_q  <= 1'b1;
				open_key_q   <= pixel_key;
				open_start_q <= col_q;
			end
		end
	end

endmodule

// ----- design/ckse_result_queue.sv -----
// ----------------------------------------------------------------------------
// ckse_result_queue
// Three-entry result queue; takes up to two spans per cycle, presents one.
// ----------------------------------------------------------------------------
`include "color_key_span_extractor_macros.svh"

module ckse_result_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ckse_pkg::core_res_t res,
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output ckse_pkg::span_t     head
);

	ckse_pkg::span_t               slot_q [ckse_pkg::Q_DEPTH];
	ckse_pkg::span_t               slot_d [ckse_pkg::Q_DEPTH];
	logic [ckse_pkg::Q_CNT_W-1:0]  cnt_q;
	logic [ckse_pkg::Q_CNT_W-1:0]  cnt_pop;
	logic [ckse_pkg::Q_CNT_W-1:0]  push_cnt;
	logic                          pop;

	assign out_valid = cnt_q != '0;
	assign head      = slot_q[0];
	assign pop       = out_valid && out_ready;
	// room for two more regardless of the consumer
	assign room      = cnt_q <= ckse_pkg::Q_CNT_W'(1);
	assign push_cnt  = push ? res.count : '0;
	assign cnt_pop   = cnt_q - ckse_pkg::Q_CNT_W'(pop);

	always_comb begin
		// advance on pop, then drop new spans in behind the survivors
		if (pop) begin
			slot_d[0] = slot_q[1];
			slot_d[1] = slot_q[2];
		end else begin
			slot_d[0] = slot_q[0];
			slot_d[1] = slot_q[1];
		end
		slot_d[2] = slot_q[2];
		for (int i = 0; i < ckse_pkg::Q_DEPTH; i++) begin
			if (push_cnt != '0 && ckse_pkg::Q_CNT_W'(i) == cnt_pop)
				slot_d[i] = res.first;
			if (push_cnt == 2'd2 && ckse_pkg::Q_CNT_W'(i) == cnt_pop + ckse_pkg::Q_CNT_W'(1))
				slot_d[i] = res.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_pop + push_cnt;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ckse_pkg::Q_DEPTH; i++)
			slot_q[i] <= slot_d[i];
	end

	`CKSE_ASSERT_IMP(a_push_has_room, clk, arst_n, push_cnt != '0, cnt_q <= 2'd1)
	`CKSE_ASSERT_IMP(a_head_key_nonzero, clk, arst_n, out_valid, slot_q[0].color_key != '0)
	`CKSE_ASSERT_NXT(a_double_push_count, clk, arst_n, push_cnt == 2'd2 && !pop,
		cnt_q == $past(cnt_q) + 2'd2)

endmodule
